// File: hw/rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types and constants for the XTEA round-cell pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned ROUNDS = 32;
  // each cycle of XTEA is two half-rounds, one cell each
  localparam int unsigned CELLS  = 2 * ROUNDS;

  localparam logic [31:0] DELTA        = 32'h9E37_79B9;
  localparam logic [31:0] SUM_DEC_INIT = 32'(64'(DELTA) * 64'(ROUNDS));

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_DIR  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0][31:0] key;
    logic             dir;   // 0 encrypt, 1 decrypt
  } xtea_cfg_t;

  // p is the word updated in this cell, q the one feeding the mix
  typedef struct packed {
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] sum;
  } xtea_word_t;

endpackage

// File: hw/rtl/xtea_round_cell.sv
// ----------------------------------------------------------------------------
// xtea_round_cell
// One XTEA half-round with its own valid/ready stage register.
// ----------------------------------------------------------------------------
module xtea_round_cell
  import xtea_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       phase,     // 0: first half of a cycle, 1: second half
  input  xtea_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  xtea_word_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output xtea_word_t out_data
);

  logic [31:0] mix;
  logic [1:0]  sel;
  logic [31:0] f;
  logic [31:0] p_new;
  logic [31:0] sum_next;
  logic        load;

  always_comb begin
    mix   = ((in_data.q << 4) ^ (in_data.q >> 5)) + in_data.q;
    // the z update selects by sum[12:11], the y update by sum[1:0]
    sel   = (phase ^ cfg.dir) ? in_data.sum[12:11] : in_data.sum[1:0];
    f     = mix ^ (in_data.sum + cfg.key[sel]);
    p_new = cfg.dir ? (in_data.p - f) : (in_data.p + f);
    if (phase) begin
      sum_next = in_data.sum;
    end else begin
      sum_next = cfg.dir ? (in_data.sum - DELTA) : (in_data.sum + DELTA);
    end
  end

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  // words swap roles every cell
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data.p   <= in_data.q;
      out_data.q   <= p_new;
      out_data.sum <= sum_next;
    end
  end

endmodule

// File: hw/rtl/xtea_block_cipher.sv
// ----------------------------------------------------------------------------
// xtea_block_cipher
// XTEA 64-bit block, 128-bit key, 32 rounds, as a chain of half-round cells.
// ----------------------------------------------------------------------------
//  channel  | signals                       | content
//  ---------+-------------------------------+-----------------------------------
//  cfg      | cfg_we, cfg_addr, cfg_wdata   | key words 0..3, direction
//  s        | s_tvalid, s_tready, s_tdata   | request: word_first, word_second
//  m        | m_tvalid, m_tready, m_tdata   | out_first, out_second
//
//  One block per cycle while m_tready is high; blocks pass every cell in order.
//  Each cell holds its own valid bit, so bubbles close up under a stall and
//  the input keeps accepting until the chain is full.
//  The last cell register drives m_tdata through a direction-selected swap.
//  rst clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module xtea_block_cipher
  import xtea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // word_first, word_second
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [63:0]           m_tdata    // out_first, out_second
);

  xtea_cfg_t  cfg;
  xtea_word_t entry;

  logic       chain_valid [CELLS+1];
  logic       chain_ready [CELLS+1];
  xtea_word_t chain_data  [CELLS+1];
  logic [CELLS-1:0] cell_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY0: cfg.key[0] <= cfg_wdata;
        REG_KEY1: cfg.key[1] <= cfg_wdata;
        REG_KEY2: cfg.key[2] <= cfg_wdata;
        REG_KEY3: cfg.key[3] <= cfg_wdata;
        REG_DIR:  cfg.dir    <= cfg_wdata[0];
        default:  ;
      endcase
    end
  end

  // decryption starts with the z update, so z enters as the updated word
  always_comb begin
    entry.p   = cfg.dir ? s_tdata[63:32] : s_tdata[31:0];
    entry.q   = cfg.dir ? s_tdata[31:0]  : s_tdata[63:32];
    entry.sum = cfg.dir ? SUM_DEC_INIT   : 32'd0;
  end

  assign chain_valid[0] = s_tvalid;
  assign chain_data[0]  = entry;
  assign s_tready       = chain_ready[0];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    xtea_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .phase     (1'(i % 2)),
      .cfg       (cfg),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
    assign cell_valid[i] = chain_valid[i+1];
  end

  // an even number of swaps leaves the words where they entered
  assign chain_ready[CELLS] = m_tready;
  assign m_tvalid           = chain_valid[CELLS];
  assign m_tdata = cfg.dir ? {chain_data[CELLS].p, chain_data[CELLS].q}
                           : {chain_data[CELLS].q, chain_data[CELLS].p};

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (cell_valid == '0))
    else $error("cell chain not empty after reset");

  a_head_free: assert property (@(posedge clk) disable iff (rst)
    !cell_valid[0] |-> s_tready)
    else $error("input stalled while first cell empty");

  a_one_per_cycle: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) <= $past($countones(cell_valid)) + 1)
    else $error("more than one block entered in a cycle");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> cell_valid[0])
    else $error("accepted request not held in first cell");

endmodule
